// ----- hdl/sfe_pkg.sv -----
// Shared types and constants of the SPI slave frame engine.
package sfe_pkg;

   localparam int BUF_DEPTH = 32;
   localparam int BUF_IDX_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int ADDR_BUF_I = 4;
   localparam int ADDR_CNT_I = ADDR_BUF_I + BUF_DEPTH;
   localparam int ADDR_END_I = ADDR_CNT_I + 4;

   localparam logic [5:0] ADDR_TX_LIMIT = 6'd3;
   localparam logic [5:0] ADDR_BUF = 6'(ADDR_BUF_I);
   localparam logic [5:0] ADDR_CNT = 6'(ADDR_CNT_I);
   localparam logic [6:0] ADDR_END = 7'(ADDR_END_I);

   localparam logic [7:0] BYTE_MASK = 8'hFF;

   typedef logic [BUF_IDX_W-1:0] buf_idx_type;

   typedef enum logic [2:0] {
      OP_ASSERT  = 3'd0,
      OP_EDGE    = 3'd1,
      OP_RELEASE = 3'd2,
      OP_WRITE   = 3'd3,
      OP_READ    = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_NONE       = 2'd0,
      ST_OK         = 2'd1,
      ST_CHECK_FAIL = 2'd2,
      ST_INCOMPLETE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CNT_RELEASE    = 2'd0,
      CNT_OK         = 2'd1,
      CNT_CHECK_FAIL = 2'd2,
      CNT_INCOMPLETE = 2'd3
   } cnt_sel_type;

   typedef struct packed {
      logic [2:0] op;
      logic       mosi;
      logic [5:0] address;
      logic [7:0] write_data;
   } req_type;

   typedef struct packed {
      logic       miso;
      logic [7:0] read_data;
      logic [1:0] frame_status;
   } rsp_type;

endpackage

// ----- hdl/sfe_core.sv -----
// Frame state, buffers and counters, with the per-beat next-state and result logic.
module sfe_core
   import sfe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    commit,
   input  req_type req,
   output rsp_type rsp
);

   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_LOW   = 3'd1,
      PH_HIGH  = 3'd2,
      PH_DATA  = 3'd3,
      PH_END   = 3'd4,
      PH_DONE  = 3'd5
   } phase_type;

   logic        active_ff, active_in;
   phase_type   phase_ff, phase_in;
   logic [2:0]  bitpos_ff, bitpos_in;
   buf_idx_type idx_ff, idx_in;
   logic [7:0]  rx_hdr_ff [4];
   logic [7:0]  rx_hdr_in [4];
   logic [7:0]  rx_buf_ff [BUF_DEPTH];
   logic [7:0]  rx_buf_in [BUF_DEPTH];
   logic [7:0]  tx_hdr_ff [3];
   logic [7:0]  tx_hdr_in [3];
   logic [7:0]  tx_buf_ff [BUF_DEPTH];
   logic [7:0]  tx_buf_in [BUF_DEPTH];
   logic [7:0]  cnt_ff [4];
   logic [7:0]  cnt_in [4];
   logic [15:0] edge_cnt_ff, edge_cnt_in;

   logic [2:0]  sh;
   logic [7:0]  tx_byte;
   logic [5:0]  buf_off;
   logic [5:0]  cnt_off;
   buf_idx_type buf_addr;
   logic [1:0]  cnt_addr;
   logic        last_bit;

   always_comb begin
      active_in   = active_ff;
      phase_in    = phase_ff;
      bitpos_in   = bitpos_ff;
      idx_in      = idx_ff;
      rx_hdr_in   = rx_hdr_ff;
      rx_buf_in   = rx_buf_ff;
      tx_hdr_in   = tx_hdr_ff;
      tx_buf_in   = tx_buf_ff;
      cnt_in      = cnt_ff;
      edge_cnt_in = edge_cnt_ff;
      rsp         = '0;

      sh       = ~bitpos_ff;
      last_bit = (bitpos_ff == 3'd7);
      buf_off  = req.address - ADDR_BUF;
      cnt_off  = req.address - ADDR_CNT;
      buf_addr = buf_off[BUF_IDX_W-1:0];
      cnt_addr = cnt_off[1:0];

      unique case (phase_ff)
         PH_START, PH_LOW, PH_HIGH: tx_byte = tx_hdr_ff[phase_ff[1:0]];
         PH_DATA:                   tx_byte = tx_buf_ff[idx_ff];
         PH_END:                    tx_byte = ~rx_hdr_ff[0] & BYTE_MASK;
         default:                   tx_byte = '0;
      endcase

      unique case (req.op)
         OP_ASSERT: begin
            if (!active_ff) begin
               for (int i = 0; i < 4; i++) begin
                  rx_hdr_in[i] = '0;
               end
               for (int i = 0; i < BUF_DEPTH; i++) begin
                  rx_buf_in[i] = '0;
               end
               active_in = 1'b1;
               phase_in  = PH_START;
               bitpos_in = '0;
               idx_in    = '0;
            end
         end
         OP_EDGE: begin
            if (active_ff) begin
               edge_cnt_in = edge_cnt_ff + 16'd1;
               if (phase_ff != PH_DONE) begin
                  rsp.miso  = tx_byte[sh];
                  bitpos_in = bitpos_ff + 3'd1;
                  if (req.mosi) begin
                     unique case (phase_ff)
                        PH_START, PH_LOW, PH_HIGH: rx_hdr_in[phase_ff[1:0]][sh] = 1'b1;
                        PH_DATA:                   rx_buf_in[idx_ff][sh] = 1'b1;
                        default:                   rx_hdr_in[3][sh] = 1'b1;
                     endcase
                  end
                  if (last_bit) begin
                     if (phase_ff == PH_DATA) begin
                        if (idx_ff != BUF_IDX_W'(BUF_DEPTH - 1)) begin
                           idx_in = idx_ff + BUF_IDX_W'(1);
                        end else begin
                           phase_in = PH_END;
                        end
                     end else begin
                        phase_in = phase_type'(phase_ff + 3'd1);
                     end
                  end
               end
            end
         end
         OP_RELEASE: begin
            if (active_ff) begin
               cnt_in[CNT_RELEASE] = cnt_ff[CNT_RELEASE] + 8'd1;
               if (phase_ff == PH_DONE) begin
                  if (rx_hdr_ff[3] == (~tx_hdr_ff[0] & BYTE_MASK)) begin
                     rsp.frame_status = ST_OK;
                     cnt_in[CNT_OK]   = cnt_ff[CNT_OK] + 8'd1;
                  end else begin
                     rsp.frame_status       = ST_CHECK_FAIL;
                     cnt_in[CNT_CHECK_FAIL] = cnt_ff[CNT_CHECK_FAIL] + 8'd1;
                  end
               end else begin
                  rsp.frame_status       = ST_INCOMPLETE;
                  cnt_in[CNT_INCOMPLETE] = cnt_ff[CNT_INCOMPLETE] + 8'd1;
               end
               active_in = 1'b0;
               phase_in  = PH_START;
               for (int i = 0; i < 3; i++) begin
                  tx_hdr_in[i] = '0;
               end
               for (int i = 0; i < BUF_DEPTH; i++) begin
                  tx_buf_in[i] = '0;
               end
            end
         end
         OP_WRITE: begin
            if (req.address < ADDR_TX_LIMIT) begin
               tx_hdr_in[req.address[1:0]] = req.write_data;
            end else if (req.address >= ADDR_BUF && req.address < ADDR_CNT) begin
               tx_buf_in[buf_addr] = req.write_data;
            end
         end
         OP_READ: begin
            priority if (req.address < ADDR_BUF) begin
               rsp.read_data = rx_hdr_ff[req.address[1:0]];
            end else if (req.address < ADDR_CNT) begin
               rsp.read_data = rx_buf_ff[buf_addr];
            end else if ({1'b0, req.address} < ADDR_END) begin
               rsp.read_data = cnt_ff[cnt_addr];
            end else begin
               rsp.read_data = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         phase_ff    <= PH_START;
         bitpos_ff   <= '0;
         idx_ff      <= '0;
         edge_cnt_ff <= '0;
         for (int i = 0; i < 4; i++) begin
            rx_hdr_ff[i] <= '0;
            cnt_ff[i]    <= '0;
         end
         for (int i = 0; i < 3; i++) begin
            tx_hdr_ff[i] <= '0;
         end
         for (int i = 0; i < BUF_DEPTH; i++) begin
            rx_buf_ff[i] <= '0;
            tx_buf_ff[i] <= '0;
         end
      end else if (commit) begin
         active_ff   <= active_in;
         phase_ff    <= phase_in;
         bitpos_ff   <= bitpos_in;
         idx_ff      <= idx_in;
         edge_cnt_ff <= edge_cnt_in;
         rx_hdr_ff   <= rx_hdr_in;
         cnt_ff      <= cnt_in;
         tx_hdr_ff   <= tx_hdr_in;
         rx_buf_ff   <= rx_buf_in;
         tx_buf_ff   <= tx_buf_in;
      end
   end

endmodule

// ----- hdl/spi_slave_frame_engine_top.sv -----
// Top level of the SPI slave frame engine: input register, core and result register.
//
// Each beat on the req channel is one SPI event (select assert, clock edge,
// select release) or one host register access, and each gives exactly one
// beat on the rsp channel. A beat is latched in an input register, worked on
// by the core's combinational logic and stored in a result register, from
// which its result appears on rsp. While rsp ready is high, the rate is one beat
// per cycle, set by the core's state update, which finishes within the cycle;
// the result register alone decides a stall when the rsp side holds ready low.
// No clearing pass is needed after reset.
module spi_slave_frame_engine_top
   import sfe_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_op,
   input  logic       req_mosi,
   input  logic [5:0] req_address,
   input  logic [7:0] req_write_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_miso,
   output logic [7:0] rsp_read_data,
   output logic [1:0] rsp_frame_status
);

   logic    in_vld_ff, in_vld_in;
   req_type in_req_ff, in_req_in;
   logic    out_vld_ff, out_vld_in;
   rsp_type out_rsp_ff, out_rsp_in;
   logic    advance;
   logic    take;
   rsp_type core_rsp;

   assign advance   = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign take      = req_valid && req_ready;

   assign in_vld_in  = take || (in_vld_ff && !advance);
   assign in_req_in  = take ? req_type'{op: req_op, mosi: req_mosi,
                                        address: req_address,
                                        write_data: req_write_data}
                            : in_req_ff;
   assign out_vld_in = advance || (out_vld_ff && !rsp_ready);
   assign out_rsp_in = advance ? core_rsp : out_rsp_ff;

   sfe_core u_core (
      .clock  (clock),
      .reset  (reset),
      .commit (advance),
      .req    (in_req_ff),
      .rsp    (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      in_req_ff  <= in_req_in;
      out_rsp_ff <= out_rsp_in;
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_miso         = out_rsp_ff.miso;
   assign rsp_read_data    = out_rsp_ff.read_data;
   assign rsp_frame_status = out_rsp_ff.frame_status;

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench of the SPI slave frame engine: directed table, random frames, scoreboard.
module testbench;
   import sfe_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [2:0] {
      PH_START, PH_LOW, PH_HIGH, PH_DATA, PH_END, PH_DONE
   } frame_phase_type;

   typedef struct packed {
      logic [2:0] op;
      logic       mosi;
      logic [5:0] address;
      logic [7:0] write_data;
      logic       typed;
      rsp_type    want_rsp;
   } directed_row_type;

   localparam logic [2:0] OP_BAD_A = 3'd5;
   localparam logic [2:0] OP_BAD_B = 3'd6;
   localparam logic [2:0] OP_BAD_C = 3'd7;
   localparam int HDR_START = 0;
   localparam int HDR_LOW = 1;
   localparam int HDR_HIGH = 2;
   localparam int HDR_END = 3;
   localparam int FRAME_EDGES = 8 * (BUF_DEPTH + 4);
   localparam int ITEM_TARGET = 1250;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int N_DIRECTED = 25;

   localparam logic [5:0] A_HDR_START = 6'(HDR_START);
   localparam logic [5:0] A_HDR_LOW = 6'(HDR_LOW);
   localparam logic [5:0] A_HDR_HIGH = 6'(HDR_HIGH);
   localparam logic [5:0] A_HDR_END = 6'(HDR_END);
   localparam logic [5:0] A_BUF_LAST = 6'(ADDR_BUF_I + BUF_DEPTH - 1);
   localparam logic [5:0] A_CNT_OK = ADDR_CNT + 6'(CNT_OK);
   localparam logic [5:0] A_CNT_INC = ADDR_CNT + 6'(CNT_INCOMPLETE);
   localparam logic [5:0] A_TOP = 6'h3F;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_op = OP_READ;
   logic       req_mosi = 1'b0;
   logic [5:0] req_address = '0;
   logic [7:0] req_write_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_miso;
   logic [7:0] rsp_read_data;
   logic [1:0] rsp_frame_status;

   logic       beat_has_typed = 1'b0;
   rsp_type    beat_typed_rsp = '0;
   logic       tx_calm = 1'b0;

   int fail_count = 0;
   int sent_items = 0;
   int checked_beats = 0;
   int cycle_count = 0;
   int full_frames_sent = 0;
   int short_frames_sent = 0;
   int ok_frames_sent = 0;
   int seen_status [4] = '{default: 0};
   int rx_stall_left = 0;
   int rx_calm_left = 0;

   logic            fe_active = 1'b0;
   frame_phase_type fe_phase = PH_START;
   logic [2:0]      fe_bit = '0;
   int              fe_byte_idx = 0;
   logic [7:0]      rx_hdr [4] = '{default: '0};
   logic [7:0]      rx_buf [BUF_DEPTH] = '{default: '0};
   logic [7:0]      tx_hdr [3] = '{default: '0};
   logic [7:0]      tx_buf [BUF_DEPTH] = '{default: '0};
   logic [7:0]      evt_cnt [4] = '{default: '0};

   rsp_type spi_results_due [$];

   directed_row_type directed_rows [N_DIRECTED] = '{
      '{OP_READ,    1'b0, A_HDR_START, 8'h00, 1'b1, '{1'b0, 8'h00, ST_NONE}},
      '{OP_READ,    1'b0, ADDR_CNT,    8'h00, 1'b1, '{1'b0, 8'h00, ST_NONE}},
      '{OP_READ,    1'b1, A_TOP,       8'hFF, 1'b1, '{1'b0, 8'h00, ST_NONE}},
      '{OP_EDGE,    1'b1, A_TOP,       8'hFF, 1'b1, '{1'b0, 8'h00, ST_NONE}},
      '{OP_RELEASE, 1'b1, A_TOP,       8'hFF, 1'b1, '{1'b0, 8'h00, ST_NONE}},
      '{OP_BAD_A,   1'b1, A_TOP,       8'hFF, 1'b1, '{1'b0, 8'h00, ST_NONE}},
      '{OP_BAD_B,   1'b1, A_HDR_START, 8'hFF, 1'b1, '{1'b0, 8'h00, ST_NONE}},
      '{OP_BAD_C,   1'b1, ADDR_BUF,    8'hFF, 1'b1, '{1'b0, 8'h00, ST_NONE}},
      '{OP_WRITE,   1'b0, A_HDR_START, 8'hFF, 1'b1, '{1'b0, 8'h00, ST_NONE}},
      '{OP_WRITE,   1'b1, A_HDR_END,   8'hA5, 1'b1, '{1'b0, 8'h00, ST_NONE}},
      '{OP_WRITE,   1'b0, ADDR_BUF,    8'hFF, 1'b1, '{1'b0, 8'h00, ST_NONE}},
      '{OP_WRITE,   1'b0, A_BUF_LAST,  8'h01, 1'b1, '{1'b0, 8'h00, ST_NONE}},
      '{OP_WRITE,   1'b0, ADDR_CNT,    8'hFF, 1'b1, '{1'b0, 8'h00, ST_NONE}},
      '{OP_WRITE,   1'b1, A_TOP,       8'hFF, 1'b1, '{1'b0, 8'h00, ST_NONE}},
      '{OP_READ,    1'b0, A_HDR_END,   8'h00, 1'b1, '{1'b0, 8'h00, ST_NONE}},
      '{OP_ASSERT,  1'b0, A_HDR_START, 8'h00, 1'b1, '{1'b0, 8'h00, ST_NONE}},
      '{OP_ASSERT,  1'b1, A_TOP,       8'hFF, 1'b0, '{1'b0, 8'h00, ST_NONE}},
      '{OP_EDGE,    1'b1, A_HDR_START, 8'h00, 1'b1, '{1'b1, 8'h00, ST_NONE}},
      '{OP_EDGE,    1'b0, A_HDR_START, 8'h00, 1'b1, '{1'b1, 8'h00, ST_NONE}},
      '{OP_READ,    1'b0, A_HDR_START, 8'h00, 1'b1, '{1'b0, 8'h80, ST_NONE}},
      '{OP_RELEASE, 1'b0, A_HDR_START, 8'h00, 1'b1, '{1'b0, 8'h00, ST_INCOMPLETE}},
      '{OP_READ,    1'b0, ADDR_CNT,    8'h00, 1'b1, '{1'b0, 8'h01, ST_NONE}},
      '{OP_READ,    1'b0, A_CNT_INC,   8'h00, 1'b1, '{1'b0, 8'h01, ST_NONE}},
      '{OP_READ,    1'b0, A_CNT_OK,    8'h00, 1'b1, '{1'b0, 8'h00, ST_NONE}},
      '{OP_EDGE,    1'b1, A_HDR_HIGH,  8'h00, 1'b1, '{1'b0, 8'h00, ST_NONE}}
   };

   spi_slave_frame_engine_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_mosi         (req_mosi),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_miso         (rsp_miso),
      .rsp_read_data    (rsp_read_data),
      .rsp_frame_status (rsp_frame_status)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) begin
         return $urandom_range(1, 2);
      end else if (r < 95) begin
         return $urandom_range(3, 6);
      end
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         return 8'h00;
      end else if (r == 1) begin
         return 8'hFF;
      end
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic coin();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic logic [5:0] any_address();
      return 6'($urandom_range(0, 63));
   endfunction

   task automatic predict_spi_beat(input logic [2:0] op, input logic mosi,
         input logic [5:0] address, input logic [7:0] write_data, output rsp_type r);
      int sh;
      int a;
      r = '0;
      a = int'(address);
      case (op)
         OP_ASSERT: begin
            if (!fe_active) begin
               foreach (rx_hdr[i]) rx_hdr[i] = '0;
               foreach (rx_buf[i]) rx_buf[i] = '0;
               fe_active = 1'b1;
               fe_phase = PH_START;
               fe_bit = '0;
               fe_byte_idx = 0;
            end
         end
         OP_EDGE: begin
            if (fe_active && fe_phase != PH_DONE) begin
               sh = 7 - int'(fe_bit);
               case (fe_phase)
                  PH_START, PH_LOW, PH_HIGH: begin
                     r.miso = tx_hdr[int'(fe_phase)][sh];
                     if (mosi) rx_hdr[int'(fe_phase)][sh] = 1'b1;
                  end
                  PH_END: begin
                     r.miso = ~rx_hdr[HDR_START][sh];
                     if (mosi) rx_hdr[HDR_END][sh] = 1'b1;
                  end
                  default: begin
                     r.miso = tx_buf[fe_byte_idx][sh];
                     if (mosi) rx_buf[fe_byte_idx][sh] = 1'b1;
                  end
               endcase
               if (fe_bit == 3'd7) begin
                  if (fe_phase == PH_DATA) begin
                     if (fe_byte_idx + 1 < BUF_DEPTH) fe_byte_idx++;
                     else fe_phase = PH_END;
                  end else begin
                     fe_phase = frame_phase_type'(fe_phase + 3'd1);
                  end
               end
               fe_bit = fe_bit + 3'd1;
            end
         end
         OP_RELEASE: begin
            if (fe_active) begin
               evt_cnt[CNT_RELEASE] = evt_cnt[CNT_RELEASE] + 8'd1;
               if (fe_phase == PH_DONE) begin
                  if (rx_hdr[HDR_END] == ~tx_hdr[HDR_START]) begin
                     r.frame_status = ST_OK;
                     evt_cnt[CNT_OK] = evt_cnt[CNT_OK] + 8'd1;
                  end else begin
                     r.frame_status = ST_CHECK_FAIL;
                     evt_cnt[CNT_CHECK_FAIL] = evt_cnt[CNT_CHECK_FAIL] + 8'd1;
                  end
               end else begin
                  r.frame_status = ST_INCOMPLETE;
                  evt_cnt[CNT_INCOMPLETE] = evt_cnt[CNT_INCOMPLETE] + 8'd1;
               end
               fe_active = 1'b0;
               fe_phase = PH_START;
               foreach (tx_hdr[i]) tx_hdr[i] = '0;
               foreach (tx_buf[i]) tx_buf[i] = '0;
            end
         end
         OP_WRITE: begin
            if (a < int'(ADDR_TX_LIMIT)) begin
               tx_hdr[a] = write_data;
            end else if (a >= ADDR_BUF_I && a < ADDR_CNT_I) begin
               tx_buf[a - ADDR_BUF_I] = write_data;
            end
         end
         OP_READ: begin
            if (a < ADDR_BUF_I) begin
               r.read_data = rx_hdr[a];
            end else if (a < ADDR_CNT_I) begin
               r.read_data = rx_buf[a - ADDR_BUF_I];
            end else if (a < ADDR_END_I) begin
               r.read_data = evt_cnt[a - ADDR_CNT_I];
            end
         end
         default: begin
         end
      endcase
   endtask

   task automatic send_beat(input logic [2:0] op, input logic mosi,
         input logic [5:0] address, input logic [7:0] write_data,
         input logic typed = 1'b0, input rsp_type want_rsp = '0);
      int gap;
      gap = (!tx_calm && $urandom_range(0, 99) < 25) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_mosi <= mosi;
      req_address <= address;
      req_write_data <= write_data;
      beat_has_typed <= typed;
      beat_typed_rsp <= want_rsp;
      do @(posedge clock); while (!req_ready);
      sent_items++;
   endtask

   task automatic wait_results_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (spi_results_due.size() != 0);
   endtask

   always @(posedge clock) begin : scoreboard
      rsp_type predicted;
      rsp_type oldest;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predict_spi_beat(req_op, req_mosi, req_address, req_write_data, predicted);
            if (beat_has_typed) predicted = beat_typed_rsp;
            spi_results_due.push_back(predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (spi_results_due.size() == 0) begin
               $error("result beat arrived with nothing outstanding");
               fail_count++;
            end else begin
               oldest = spi_results_due.pop_front();
               checked_beats++;
               seen_status[rsp_frame_status]++;
               if (rsp_miso !== oldest.miso) begin
                  $error("miso mismatch: expected %0d, actual %0d", oldest.miso, rsp_miso);
                  fail_count++;
               end
               if (rsp_read_data !== oldest.read_data) begin
                  $error("read_data mismatch: expected 0x%02h, actual 0x%02h",
                         oldest.read_data, rsp_read_data);
                  fail_count++;
               end
               if (rsp_frame_status !== oldest.frame_status) begin
                  $error("frame_status mismatch: expected %0d, actual %0d",
                         oldest.frame_status, rsp_frame_status);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (rx_stall_left > 0) begin
         rsp_ready <= 1'b0;
         rx_stall_left <= rx_stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (rx_calm_left > 0) begin
            rx_calm_left <= rx_calm_left - 1;
         end else if ($urandom_range(0, 99) < 2) begin
            rx_calm_left <= $urandom_range(50, 300);
         end else if ($urandom_range(0, 99) < 20) begin
            rx_stall_left <= pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      int kind;
      int n_edges;
      logic [7:0] start_byte;
      logic [7:0] end_byte;
      logic bit_in;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_beat(directed_rows[i].op, directed_rows[i].mosi, directed_rows[i].address,
                   directed_rows[i].write_data, directed_rows[i].typed,
                   directed_rows[i].want_rsp);
      end
      wait_results_drained();

      while (sent_items < ITEM_TARGET || ok_frames_sent < 3) begin
         tx_calm = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(3, 20)) begin
               send_beat(3'($urandom_range(OP_ASSERT, OP_BAD_C)), coin(), any_address(),
                         pick_byte());
            end
            send_beat(OP_RELEASE, coin(), any_address(), pick_byte());
         end

         kind = $urandom_range(0, 9);
         start_byte = pick_byte();
         end_byte = (kind == 4) ? pick_byte() : ~start_byte;
         if (kind <= 5) begin
            n_edges = FRAME_EDGES + ((kind == 5) ? $urandom_range(1, 24) : 0);
         end else if (kind <= 7) begin
            n_edges = $urandom_range(0, 40);
         end else begin
            n_edges = $urandom_range(41, FRAME_EDGES - 1);
         end

         send_beat(OP_WRITE, coin(), A_HDR_START, start_byte);
         send_beat(OP_WRITE, coin(), A_HDR_LOW, pick_byte());
         send_beat(OP_WRITE, coin(), A_HDR_HIGH, pick_byte());
         repeat ($urandom_range(0, 8)) begin
            send_beat(OP_WRITE, coin(), 6'(ADDR_BUF_I + $urandom_range(0, BUF_DEPTH - 1)),
                      pick_byte());
         end
         send_beat(OP_ASSERT, coin(), any_address(), pick_byte());
         for (int e = 0; e < n_edges; e++) begin
            if ($urandom_range(0, 99) < 3) begin
               case ($urandom_range(0, 3))
                  0: send_beat(OP_ASSERT, coin(), any_address(), pick_byte());
                  1: send_beat(OP_READ, coin(), any_address(), pick_byte());
                  2: send_beat(OP_WRITE, coin(), 6'($urandom_range(1, 63)), pick_byte());
                  default: send_beat(3'($urandom_range(OP_BAD_A, OP_BAD_C)), coin(),
                                     any_address(), pick_byte());
               endcase
            end
            if (e >= FRAME_EDGES - 8 && e < FRAME_EDGES) bit_in = end_byte[7 - (e % 8)];
            else bit_in = coin();
            send_beat(OP_EDGE, bit_in, any_address(), pick_byte());
         end
         send_beat(OP_RELEASE, coin(), any_address(), pick_byte());

         if (kind <= 5) full_frames_sent++;
         else short_frames_sent++;
         if (kind <= 3 || kind == 5) ok_frames_sent++;

         repeat ($urandom_range(1, 6)) begin
            send_beat(OP_READ, coin(), 6'($urandom_range(0, ADDR_END_I - 1)), pick_byte());
         end
         if ($urandom_range(0, 4) == 0) wait_results_drained();
      end

      wait_results_drained();
      repeat (10) @(posedge clock);
      $display("Checked %0d beats: %0d full frames and %0d cut-short frames with host traffic.",
               checked_beats, full_frames_sent, short_frames_sent);
      $display("Releases seen: %0d ok, %0d checksum fail, %0d incomplete.",
               seen_status[ST_OK], seen_status[ST_CHECK_FAIL], seen_status[ST_INCOMPLETE]);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
